// ===== sv/pwl_pkg.sv =====
// ---------------------------------------------------------------------------
// pwl_pkg: shared types and constants of the piecewise-linear lookup
// Field widths, status and function codes, and the default table depth.
// ---------------------------------------------------------------------------
package pwl_pkg;

	localparam int MAX_POINTS_DEF = 8;

	localparam int TEMP_W = 15;
	localparam int RES_W  = 32;
	localparam int CNT_W  = 4;
	localparam int IDX_W  = 3;
	localparam int STAT_W = 2;

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic [RES_W-1:0]         res_t;
	typedef logic [STAT_W-1:0]        status_t;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam status_t ST_OK         = 2'd0;
	localparam status_t ST_TOO_FEW    = 2'd1;
	localparam status_t ST_CLAMP_ZERO = 2'd2;
	localparam status_t ST_CLAMP_MAX  = 2'd3;

endpackage

// ===== sv/pwl_ram.sv =====
// ---------------------------------------------------------------------------
// pwl_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle; contents not reset.
// ---------------------------------------------------------------------------
module pwl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/piecewise_linear_resistance_lookup_top.sv =====
// ---------------------------------------------------------------------------
// piecewise_linear_resistance_lookup_top: temperature to resistance lookup
// Table of (temperature, resistance) points; queries interpolate linearly
// between the bracketing pair, extrapolate at the ends, and saturate.
// ---------------------------------------------------------------------------
//
//   channel  handshake            payload
//   in       in_valid/in_ready    func, point_index, point/query temperature, point_resistance
//   out      out_valid/out_ready  resistance, status
//   cfg      cfg_valid/cfg_ready  cfg_data (points in use)
//
// Writes and too-few queries go straight to the finish state. A query scans one
// slot per cycle, multiplies once, then divides one quotient bit per cycle for a
// 48-bit quotient on a shared 17-bit subtractor, then rounds, adds and saturates;
// the divide and round are skipped when the chosen pair has equal temperatures.
// in_ready is high only in idle; a stalled output word holds up only the next
// result. cfg is always ready; arst_n clears control state, the table has no reset.
// ---------------------------------------------------------------------------
module piecewise_linear_resistance_lookup_top #(
	parameter int MAX_POINTS = pwl_pkg::MAX_POINTS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    func,
	input  logic [pwl_pkg::IDX_W-1:0] point_index,
	input  pwl_pkg::temp_t          point_temperature,
	input  pwl_pkg::res_t           point_resistance,
	input  pwl_pkg::temp_t          query_temperature,
	output logic                    out_valid,
	input  logic                    out_ready,
	output pwl_pkg::res_t           resistance,
	output pwl_pkg::status_t        status,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [pwl_pkg::CNT_W-1:0] cfg_data
);
	import pwl_pkg::*;

	localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int EW   = TEMP_W + RES_W;
	localparam int MAGW = 48;
	localparam int DCW  = 6;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_LD0    = 4'd1;
	localparam logic [3:0] S_LD1    = 4'd2;
	localparam logic [3:0] S_SCAN   = 4'd3;
	localparam logic [3:0] S_MUL    = 4'd4;
	localparam logic [3:0] S_PREP   = 4'd5;
	localparam logic [3:0] S_DIV    = 4'd6;
	localparam logic [3:0] S_ROUND  = 4'd7;
	localparam logic [3:0] S_ADD    = 4'd8;
	localparam logic [3:0] S_SAT    = 4'd9;
	localparam logic [3:0] S_FINISH = 4'd10;

	logic [3:0]       state_q;
	logic [CNT_W-1:0] npts_q;
	logic [CNT_W-1:0] n_eff;
	logic             in_acc;
	logic             out_free;

	// table memory
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] addr_q;
	logic [EW-1:0] ram_rdata;
	temp_t         rd_t;
	res_t          rd_r;

	// scan state
	temp_t            t_q;
	logic [CNT_W-1:0] hi_q;
	temp_t            lo_t_q;
	temp_t            hi_t_q;
	res_t             lo_r_q;
	res_t             hi_r_q;
	logic             stop_w;

	// arithmetic
	logic signed [15:0] dx_w;
	logic signed [15:0] dt_w;
	logic signed [32:0] dy_w;
	logic signed [48:0] prod_w;
	logic signed [48:0] prod_q;
	logic signed [15:0] dx_q;
	logic signed [48:0] pabs_w;
	logic signed [15:0] dxn_w;
	logic               neg_q;
	logic [15:0]        dxabs_q;
	logic [MAGW-1:0]    quo_q;
	logic [15:0]        rem_q;
	logic [DCW-1:0]     cnt_q;
	logic [16:0]        part_w;
	logic [16:0]        diff_w;
	logic               ge_w;
	logic               rnd_w;
	logic [MAGW-1:0]    q_q;
	logic signed [49:0] qs_w;
	logic signed [49:0] sum_q;

	// pending result
	res_t    res_q;
	status_t stat_q;
	res_t    out_res_q;
	status_t out_stat_q;
	logic    out_valid_q;

	assign n_eff     = (int'(npts_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : npts_q;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign resistance = out_res_q;
	assign status     = out_stat_q;

	assign ram_we    = in_acc && (func == FUNC_WRITE) && (int'(point_index) < MAX_POINTS);
	assign ram_waddr = AW'(point_index);

	pwl_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_POINTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata({point_temperature, point_resistance}),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	assign rd_t = temp_t'(ram_rdata[EW-1:RES_W]);
	assign rd_r = ram_rdata[RES_W-1:0];

	// equality counts as bracketing; two points above the target also stop
	assign stop_w = (lo_t_q <= t_q && t_q <= rd_t) || (t_q < lo_t_q && t_q < rd_t)
		|| ({1'b0, hi_q} + 5'd1 >= {1'b0, n_eff});

	assign dx_w   = 16'(hi_t_q) - 16'(lo_t_q);
	assign dt_w   = 16'(t_q) - 16'(lo_t_q);
	assign dy_w   = $signed({1'b0, hi_r_q}) - $signed({1'b0, lo_r_q});
	assign prod_w = dt_w * dy_w;

	assign pabs_w = prod_q[48] ? -prod_q : prod_q;
	assign dxn_w  = dx_q[15] ? -dx_q : dx_q;

	// shared restoring divide step
	assign part_w = {rem_q, quo_q[MAGW-1]};
	assign diff_w = part_w - {1'b0, dxabs_q};
	assign ge_w   = part_w >= {1'b0, dxabs_q};
	assign rnd_w  = {rem_q, 1'b0} >= {1'b0, dxabs_q};

	assign qs_w = neg_q ? -$signed({2'b00, q_q}) : $signed({2'b00, q_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			npts_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			npts_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			addr_q  <= '0;
			hi_q    <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						addr_q <= '0;
						hi_q   <= CNT_W'(1);
						if (func == FUNC_WRITE || n_eff < CNT_W'(2)) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_LD0;
						end
					end
				end
				S_LD0: begin
					addr_q  <= addr_q + AW'(1);
					state_q <= S_LD1;
				end
				S_LD1: begin
					addr_q  <= addr_q + AW'(1);
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (stop_w) begin
						state_q <= S_MUL;
					end else begin
						addr_q <= addr_q + AW'(1);
						hi_q   <= hi_q + CNT_W'(1);
					end
				end
				S_MUL: begin
					state_q <= S_PREP;
				end
				S_PREP: begin
					cnt_q <= DCW'(MAGW - 1);
					if (dx_q == 16'sd0) begin
						state_q <= S_ADD;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - DCW'(1);
					if (cnt_q == '0) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					state_q <= S_SAT;
				end
				S_SAT: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				t_q    <= query_temperature;
				res_q  <= '0;
				stat_q <= (func == FUNC_QUERY) ? ST_TOO_FEW : ST_OK;
			end
			S_LD1: begin
				lo_t_q <= rd_t;
				lo_r_q <= rd_r;
			end
			S_SCAN: begin
				if (stop_w) begin
					hi_t_q <= rd_t;
					hi_r_q <= rd_r;
				end else begin
					lo_t_q <= rd_t;
					lo_r_q <= rd_r;
				end
			end
			S_MUL: begin
				prod_q <= prod_w;
				dx_q   <= dx_w;
			end
			S_PREP: begin
				neg_q   <= prod_q[48] ^ dx_q[15];
				dxabs_q <= dxn_w;
				quo_q   <= pabs_w[MAGW-1:0];
				rem_q   <= '0;
				q_q     <= '0;
			end
			S_DIV: begin
				rem_q <= ge_w ? diff_w[15:0] : part_w[15:0];
				quo_q <= {quo_q[MAGW-2:0], ge_w};
			end
			S_ROUND: begin
				q_q <= quo_q + MAGW'(rnd_w);
			end
			S_ADD: begin
				sum_q <= $signed({18'd0, lo_r_q}) + qs_w;
			end
			S_SAT: begin
				if (sum_q < 50'sd0) begin
					res_q  <= '0;
					stat_q <= ST_CLAMP_ZERO;
				end else if (sum_q[49:RES_W] != '0) begin
					res_q  <= '1;
					stat_q <= ST_CLAMP_MAX;
				end else begin
					res_q  <= sum_q[RES_W-1:0];
					stat_q <= ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			out_res_q  <= res_q;
			out_stat_q <= stat_q;
		end
	end

endmodule

// ===== sv/pwl_chk.sv =====
// ---------------------------------------------------------------------------
// pwl_chk: port-level checks for the resistance lookup
// Watches handshakes and result words; bound to the top level.
// ---------------------------------------------------------------------------
module pwl_chk (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input pwl_pkg::res_t           resistance,
	input pwl_pkg::status_t        status
);
	import pwl_pkg::*;

	// one item at a time: busy right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while previous item in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(resistance) && $stable(status))
		else $error("stalled result word changed");

	a_too_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_TOO_FEW |-> resistance == '0)
		else $error("too-few result carries nonzero resistance");

	a_clamp_values: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_CLAMP_MAX || status == ST_CLAMP_ZERO) |->
		(status == ST_CLAMP_MAX && resistance == '1)
		|| (status == ST_CLAMP_ZERO && resistance == '0))
		else $error("clamped result not at range limit");

endmodule

bind piecewise_linear_resistance_lookup_top pwl_chk u_pwl_chk (.*);

// ===== test/pwl_lookup_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pwl_lookup_checker: result predictor and comparator for the resistance lookup
// Watches the config, input and output channels. It keeps its own copy of the
// point table and the points-in-use count, works out the expected word for each
// accepted input word, and compares the output words in order.
// ---------------------------------------------------------------------------
module pwl_lookup_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       func,
	input  logic [pwl_pkg::IDX_W-1:0]  point_index,
	input  pwl_pkg::temp_t             point_temperature,
	input  pwl_pkg::res_t              point_resistance,
	input  pwl_pkg::temp_t             query_temperature,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  pwl_pkg::res_t              resistance,
	input  pwl_pkg::status_t           status,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [pwl_pkg::CNT_W-1:0]  cfg_data,
	output int                         errors,
	output int                         outstanding
);
	import pwl_pkg::*;

	localparam longint RES_MAX = 64'd4294967295;

	typedef struct packed {
		res_t    resistance;
		status_t status;
	} lookup_word_t;

	temp_t            point_temps [MAX_POINTS_DEF];
	res_t             point_res   [MAX_POINTS_DEF];
	logic [CNT_W-1:0] points_in_use;
	lookup_word_t     expected_words [$];

	function automatic lookup_word_t lookup_resistance(input temp_t target);
		lookup_word_t     w;
		int               n;
		int               lo;
		int               hi;
		longint           dx;
		longint           dy;
		longint           num;
		longint           q;
		longint           r;
		longint unsigned  mag;
		w.resistance = '0;
		w.status = ST_OK;
		n = (points_in_use > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(points_in_use);
		if (n < 2) begin
			w.status = ST_TOO_FEW;
			return w;
		end
		lo = 0;
		hi = 1;
		// stop on a bracketing pair, on a pair wholly above, or at the last pair
		while (!((point_temps[lo] <= target && target <= point_temps[hi]) ||
				(target < point_temps[lo] && target < point_temps[hi])) && hi + 1 < n) begin
			lo = hi;
			hi = hi + 1;
		end
		dx = longint'(point_temps[hi]) - longint'(point_temps[lo]);
		dy = longint'({32'd0, point_res[hi]}) - longint'({32'd0, point_res[lo]});
		num = (longint'(target) - longint'(point_temps[lo])) * dy;
		q = 0;
		if (dx != 0) begin
			if (dx < 0) begin
				dx = -dx;
				num = -num;
			end
			mag = (num < 0) ? -num : num;
			// round half away from zero on the magnitude
			mag = (mag * 2 + dx) / (dx * 2);
			q = (num < 0) ? -longint'(mag) : longint'(mag);
		end
		r = longint'({32'd0, point_res[lo]}) + q;
		if (r < 0) begin
			w.resistance = '0;
			w.status = ST_CLAMP_ZERO;
		end else if (r > RES_MAX) begin
			w.resistance = '1;
			w.status = ST_CLAMP_MAX;
		end else begin
			w.resistance = r[RES_W-1:0];
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		lookup_word_t want;
		if (!arst_n) begin
			expected_words.delete();
			points_in_use = '0;
			outstanding = 0;
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				points_in_use = cfg_data;
			if (in_valid && in_ready) begin
				if (func == FUNC_WRITE) begin
					point_temps[point_index] = point_temperature;
					point_res[point_index] = point_resistance;
					want.resistance = '0;
					want.status = ST_OK;
				end else begin
					want = lookup_resistance(query_temperature);
				end
				expected_words = {expected_words, want};
			end
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word: resistance %0d status %0d", resistance, status);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (resistance !== want.resistance) begin
						$error("resistance: expected %0d, actual %0d", want.resistance,
							resistance);
						errors++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						errors++;
					end
				end
			end
			outstanding = expected_words.size();
		end
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for the piecewise-linear resistance lookup
// Directed point writes and queries over the special cases, then rounds of
// random tables and queries under changing idle and stall patterns. Checking
// is done by the checker instance beside the block.
// ---------------------------------------------------------------------------
module testbench;
	import pwl_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int HOLD_CYCLES  = 500;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int ROUNDS       = 16;
	localparam int ROUND_ITEMS  = 60;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             func = FUNC_WRITE;
	logic [IDX_W-1:0] point_index = '0;
	temp_t            point_temperature = '0;
	res_t             point_resistance = '0;
	temp_t            query_temperature = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	res_t             resistance;
	status_t          status;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;

	int    check_errors;
	int    check_outstanding;
	int    send_idle_pct = 0;
	int    recv_stall_pct = 0;
	int    hold_req = 0;
	int    hold_seen = 0;
	int    hold_left = 0;
	int    cycles = 0;
	temp_t table_temps [MAX_POINTS_DEF];

	piecewise_linear_resistance_lookup_top DUT (.*);

	pwl_lookup_checker u_checker (
		.*,
		.errors(check_errors),
		.outstanding(check_outstanding)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off counted here on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic send_word(input logic f, input logic [IDX_W-1:0] idx, input temp_t pt,
			input res_t pr, input temp_t qt);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct && gap < 40)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		point_index <= idx;
		point_temperature <= pt;
		point_resistance <= pr;
		query_temperature <= qt;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	task automatic write_point(input int slot, input temp_t t, input res_t r);
		table_temps[slot] = t;
		send_word(FUNC_WRITE, slot[IDX_W-1:0], t, r, temp_t'($urandom));
	endtask

	task automatic query(input temp_t t);
		send_word(FUNC_QUERY, IDX_W'($urandom), temp_t'($urandom), $urandom, t);
	endtask

	task automatic wait_drained;
		in_valid <= 1'b0;
		do @(negedge clk); while (check_outstanding != 0);
		@(posedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] n);
		cfg_valid <= 1'b1;
		cfg_data <= n;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly inside the span of the points in use, some on or next to a point, some anywhere
	function automatic temp_t pick_query_temp(input int n);
		int k;
		int lo;
		int hi;
		int sel;
		k = (n > MAX_POINTS_DEF) ? MAX_POINTS_DEF - 1 : ((n < 1) ? 0 : n - 1);
		lo = table_temps[0];
		hi = table_temps[k];
		if (lo > hi) begin
			sel = lo;
			lo = hi;
			hi = sel;
		end
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return temp_t'(int'($urandom_range(0, hi - lo)) + lo);
		else if (sel < 7)
			return temp_t'(int'(table_temps[$urandom_range(0, k)]) +
				int'($urandom_range(0, 2)) - 1);
		return temp_t'($urandom);
	endfunction

	initial begin
		int   n;
		int   t_int;
		int   res_style;
		res_t r_acc;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_count(0);
		query(0);

		// equal temperatures in slots 0 and 1, steep drop after slot 4
		write_point(0, -2048, 32'h0000_0000);
		write_point(1, -2048, 32'h1000_0000);
		write_point(2, -1024, 32'h2000_0000);
		write_point(3, 0, 32'h3000_0000);
		write_point(4, 1600, 32'hFFFF_FFFF);
		write_point(5, 4000, 32'h0000_0010);
		write_point(6, 8000, 32'h0000_0100);
		write_point(7, 16383, 32'hFFFF_FFF0);

		wait_drained;
		write_count(1);
		query(0);

		wait_drained;
		write_count(2);
		query(5000);

		wait_drained;
		write_count(8);
		query(-16384);
		query(-1500);
		query(2000);
		query(16383);

		// extrapolation above the last pair in use overflows
		wait_drained;
		write_count(5);
		query(3000);
		query(16383);

		// extrapolation along the falling pair goes negative
		wait_drained;
		write_count(6);
		query(8000);

		wait_drained;
		write_count(15);
		query(100);
		write_point(0, -16384, 32'hFFFF_FFFF);
		query(-16384);
		// slot 0 now above slot 1: unordered table
		write_point(0, -1000, 32'h0000_0001);
		query(-3000);

		for (int round_no = 0; round_no < ROUNDS; round_no++) begin
			wait_drained;
			case (round_no % 4)
				0: begin
					send_idle_pct <= 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct <= 76;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct <= 0;
					recv_stall_pct <= 76;
				end
				default: begin
					send_idle_pct <= 10;
					recv_stall_pct <= 10;
				end
			endcase
			case ($urandom_range(0, 9))
				0: n = $urandom_range(0, 1);
				1: n = $urandom_range(MAX_POINTS_DEF + 1, 15);
				default: n = $urandom_range(2, MAX_POINTS_DEF);
			endcase
			write_count(n[CNT_W-1:0]);
			if (round_no == 2 || round_no == 9)
				hold_req <= hold_req + 1;

			// fresh table in non-decreasing temperature order
			res_style = $urandom_range(0, 3);
			t_int = int'($urandom_range(0, 20000)) - 16384;
			r_acc = $urandom_range(0, 32'h7FFF_FFFF);
			for (int slot = 0; slot < MAX_POINTS_DEF; slot++) begin
				if (slot != 0) begin
					if ($urandom_range(0, 3) == 0)
						t_int += int'($urandom_range(0, 2));
					else
						t_int += int'($urandom_range(0, (16383 - t_int) / (MAX_POINTS_DEF - slot)));
					if (t_int > 16383)
						t_int = 16383;
					r_acc += $urandom_range(0, 32'h0FFF_FFFF);
				end
				write_point(slot, temp_t'(t_int), (res_style == 0) ? res_t'($urandom) : r_acc);
			end

			for (int k = 0; k < ROUND_ITEMS; k++) begin
				if (round_no == 5 && k == ROUND_ITEMS / 2)
					wait_drained;
				if ($urandom_range(0, 99) < 15)
					write_point($urandom_range(0, MAX_POINTS_DEF - 1), temp_t'($urandom), $urandom);
				else
					query(pick_query_temp(n));
			end
		end

		wait_drained;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (check_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/pwl_pkg.sv
sv/pwl_ram.sv
sv/piecewise_linear_resistance_lookup_top.sv
sv/pwl_chk.sv
test/pwl_lookup_checker.sv
test/testbench.sv
